### rtl/b32c_pkg.sv
// Shared types, constants and alphabet table for the base32 stream codec.
`default_nettype none

package b32c_pkg;

    localparam int unsigned ACC_W  = 12;
    localparam int unsigned PEND_W = 4;
    localparam int unsigned BITS_W = 20;
    localparam int unsigned CAP_W  = 16;

    localparam logic [CAP_W-1:0] CAPACITY_RESET = 16'hffff;

    // Configuration register indexes.
    localparam logic CFG_DIRECTION = 1'b0;
    localparam logic CFG_CAPACITY  = 1'b1;

    localparam logic DIR_DECODE = 1'b0;
    localparam logic DIR_ENCODE = 1'b1;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_UNKNOWN = 2'd1,
        ST_FULL    = 2'd2
    } t_status;

    typedef logic [7:0] t_char_table [32];

    localparam t_char_table ALPHABET = '{
        8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
        8'h38, 8'h39, 8'h61, 8'h62, 8'h63, 8'h64, 8'h65, 8'h66,
        8'h67, 8'h68, 8'h6a, 8'h6b, 8'h6d, 8'h6e, 8'h70, 8'h71,
        8'h72, 8'h73, 8'h74, 8'h76, 8'h77, 8'h78, 8'h79, 8'h7a
    };

    typedef struct packed {
        logic [ACC_W-1:0]  acc;
        logic [PEND_W-1:0] pend;
        logic [BITS_W-1:0] bits;
        logic              discard;
    } t_state;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        t_status    status;
    } t_result;

    // Up to three results produced by one item.
    typedef struct packed {
        logic [1:0]    count;
        t_result [2:0] res;
    } t_burst;

endpackage

`default_nettype wire

### rtl/b32c_step.sv
// Combinational step logic: next stream state and the burst of results for one item.
`default_nettype none

module b32c_step (
    input  wire logic                      i_direction,
    input  wire logic [b32c_pkg::CAP_W-1:0] i_capacity,
    input  wire b32c_pkg::t_state          i_state,
    input  wire logic [7:0]                i_data,
    input  wire logic                      i_last,
    output b32c_pkg::t_state               o_state,
    output b32c_pkg::t_burst               o_burst
);

    // Decode path signals.
    logic        found;
    logic [4:0]  sym;
    logic [19:0] cap_bits;
    logic [19:0] room;
    logic [2:0]  sbits;
    logic [16:0] dcat;
    logic [16:0] dshift;
    logic [11:0] dacc1;
    logic [11:0] dacc2;
    logic [3:0]  dpend1;
    logic [3:0]  dpend2;

    // Encode path signals.
    logic [19:0] ecat;
    logic [11:0] eacc1;
    logic [11:0] eacc2;
    logic [11:0] eacc3;
    logic [3:0]  epend1;
    logic [3:0]  epend2;
    logic [3:0]  epend3;

    logic [1:0]  n;
    b32c_pkg::t_burst burst;
    b32c_pkg::t_state st;

    always_comb begin
        found = 1'b0;
        sym   = 5'd0;
        for (int j = 0; j < 32; j++) begin
            if (!found && b32c_pkg::ALPHABET[j] == i_data) begin
                found = 1'b1;
                sym   = 5'(j);
            end
        end
    end

    always_comb begin
        cap_bits = {1'b0, i_capacity, 3'b000};
        room     = cap_bits - i_state.bits;
        sbits    = (room < 20'd5) ? room[2:0] : 3'd5;
        dcat     = {i_state.acc, sym};
        dshift   = dcat >> (3'd5 - sbits);
        dacc1    = dshift[11:0];
        dpend1   = i_state.pend + {1'b0, sbits};
        dpend2   = (dpend1 >= 4'd8) ? (dpend1 - 4'd8) : dpend1;
        dacc2    = (dpend1 >= 4'd8) ? (dacc1 & ~(12'hfff << dpend2)) : dacc1;

        ecat     = {i_state.acc, i_data};
        eacc1    = ecat[11:0];
        epend1   = i_state.pend + 4'd8;
        epend2   = epend1 - 4'd5;
        eacc2    = eacc1 & ~(12'hfff << epend2);
        epend3   = (epend2 >= 4'd5) ? (epend2 - 4'd5) : epend2;
        eacc3    = (epend2 >= 4'd5) ? (eacc2 & ~(12'hfff << epend3)) : eacc2;
    end

    always_comb begin
        st    = i_state;
        burst = '0;
        n     = 2'd0;

        if (i_state.discard) begin
            if (i_last) begin
                st = '0;
            end
        end else if (i_direction == b32c_pkg::DIR_ENCODE) begin
            burst.res[n].data = b32c_pkg::ALPHABET[5'(eacc1 >> epend2)];
            n = n + 2'd1;
            if (epend2 >= 4'd5) begin
                burst.res[n].data = b32c_pkg::ALPHABET[5'(eacc2 >> epend3)];
                n = n + 2'd1;
            end
            st.acc  = eacc3;
            st.pend = epend3;
            if (i_last) begin
                if (epend3 != 4'd0) begin
                    burst.res[n].data = b32c_pkg::ALPHABET[5'(eacc3 << (4'd5 - epend3))];
                    n = n + 2'd1;
                end
                burst.res[n - 2'd1].last = 1'b1;
                st = '0;
            end
        end else if (!found || i_state.bits >= cap_bits) begin
            // Error: a single terminating result, then drop the rest of the stream.
            burst.res[0].last   = 1'b1;
            burst.res[0].status = found ? b32c_pkg::ST_FULL : b32c_pkg::ST_UNKNOWN;
            n          = 2'd1;
            st         = '0;
            st.discard = !i_last;
        end else begin
            if (dpend1 >= 4'd8) begin
                burst.res[n].data = 8'(dacc1 >> dpend2);
                n = n + 2'd1;
            end
            st.acc  = dacc2;
            st.pend = dpend2;
            st.bits = i_state.bits + {17'd0, sbits};
            if (i_last) begin
                if (dpend2 != 4'd0) begin
                    burst.res[n].data = 8'(dacc2 << (4'd8 - dpend2));
                    n = n + 2'd1;
                end
                if (n != 2'd0) begin
                    burst.res[n - 2'd1].last = 1'b1;
                end
                st = '0;
            end
        end
        burst.count = n;
    end

    assign o_state = st;
    assign o_burst = burst;

endmodule

`default_nettype wire

### rtl/b32c_res_buf.sv
// Result buffer: holds the burst of one item and hands it out one transfer per cycle while i_stall is low.
`default_nettype none

module b32c_res_buf (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_load,
    input  wire b32c_pkg::t_burst i_burst,
    output logic                  o_free,
    output logic                  o_valid,
    input  wire logic             i_stall,
    output b32c_pkg::t_result     o_result
);

    b32c_pkg::t_result [2:0] r_res;
    logic [1:0]              r_cnt;
    logic [1:0]              r_head;
    logic                    take;

    assign o_valid  = (r_cnt != 2'd0);
    assign take     = o_valid && !i_stall;
    assign o_free   = (r_cnt == 2'd0) || (r_cnt == 2'd1 && take);
    assign o_result = r_res[r_head];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= 2'd0;
            r_head <= 2'd0;
        end else if (i_load) begin
            r_cnt  <= i_burst.count;
            r_head <= 2'd0;
        end else if (take) begin
            r_cnt  <= r_cnt - 2'd1;
            r_head <= r_head + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_burst.res;
        end
    end

endmodule

`default_nettype wire

### rtl/base32_stream_codec_top.sv
// Top level of the base32 stream codec: input register, stream state and result buffer.
//
// Input channel i_valid/o_stall carries one character (decode) or one byte (encode) per
// transfer on i_in_data, with i_in_last marking the end of a stream. The output channel
// o_valid/i_stall carries one result per transfer: a decoded byte or an alphabet
// character on o_out_data, o_out_last on the final result of a stream, and o_out_status
// giving an unknown symbol or a full destination. An error ends the stream with a single
// result and the remaining items up to the next last marker give no output.
// Configuration is written through i_cfg_we/i_cfg_index/i_cfg_data; the user must do this
// only while the block is idle, which the block does not enforce. Writing the direction
// register also clears the stream state. An accepted item lands in the input register, and
// the step logic's results for it are loaded into the result buffer once that buffer is free.
// Each item yields zero to three results, which the result buffer hands out one per cycle
// while the receiver does not stall; a new item is then taken every cycle while items give
// at most one result, otherwise the next item is loaded as the last result of the current
// one is transferred. The input register lets one item wait while the buffer drains.
// When the receiver stalls, the current result holds and the input register fills, after
// which o_stall rises. Reset empties both registers, clears the stream state and sets
// decode direction with the full 65535 byte capacity.
`default_nettype none

module base32_stream_codec_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [7:0]  i_in_data,
    input  wire logic        i_in_last,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [7:0]       o_out_data,
    output logic             o_out_last,
    output logic [1:0]       o_out_status,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_index,
    input  wire logic [15:0] i_cfg_data
);

    logic                           r_direction;
    logic [b32c_pkg::CAP_W-1:0]     r_capacity;
    b32c_pkg::t_state               r_state;
    b32c_pkg::t_state               n_state;
    logic                           r_in_valid;
    logic [7:0]                     r_in_data;
    logic                           r_in_last;
    b32c_pkg::t_burst               burst;
    b32c_pkg::t_result              result;
    logic                           buf_free;
    logic                           load;
    logic                           accept;

    assign load    = r_in_valid && buf_free;
    assign o_stall = r_in_valid && !buf_free;
    assign accept  = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (accept) begin
            r_in_valid <= 1'b1;
        end else if (load) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in_data <= i_in_data;
            r_in_last <= i_in_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_direction <= b32c_pkg::DIR_DECODE;
            r_capacity  <= b32c_pkg::CAPACITY_RESET;
            r_state     <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                b32c_pkg::CFG_DIRECTION: begin
                    r_direction <= i_cfg_data[0];
                    r_state     <= '0;
                end
                b32c_pkg::CFG_CAPACITY: begin
                    r_capacity <= i_cfg_data;
                end
                default: begin
                    r_capacity <= r_capacity;
                end
            endcase
        end else if (load) begin
            r_state <= n_state;
        end
    end

    b32c_step u_step (
        .i_direction (r_direction),
        .i_capacity  (r_capacity),
        .i_state     (r_state),
        .i_data      (r_in_data),
        .i_last      (r_in_last),
        .o_state     (n_state),
        .o_burst     (burst)
    );

    b32c_res_buf u_res_buf (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (load),
        .i_burst  (burst),
        .o_free   (buf_free),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .o_result (result)
    );

    assign o_out_data   = result.data;
    assign o_out_last   = result.last;
    assign o_out_status = result.status;

endmodule

`default_nettype wire
